// ===== src/lvae_pkg.sv =====
// ----------------------------------------------------------------------------
// lvae_pkg: shared definitions for the lagged velocity activity estimator
// Ring geometry, field widths, register indexes and controller/datapath links.
// ----------------------------------------------------------------------------
package lvae_pkg;

   // Ring geometry.
   localparam int RING_DEPTH = 16;
   localparam int LAG        = 5;
   localparam int SLOT_W     = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int LAG_MOD    = LAG % RING_DEPTH;
   localparam bit LAG_ALIAS  = (LAG_MOD == 0);

   // Field widths.
   localparam int FRAC_W  = 18;
   localparam int DEPTH_W = 16;
   localparam int TIME_W  = 32;
   localparam int SCALE_W = 18;
   localparam int PIC_W   = 18;
   localparam int POS_W   = 20;
   localparam int VEL_W   = 32;
   localparam int ACT_W   = 33;

   // Division geometry: |delta| * 1000 * 2^16 over a 32-bit gap.
   localparam int MAG_W      = POS_W + 1;
   localparam int MUL_W      = MAG_W + 10;
   localparam int DIVIDEND_W = MUL_W + 16;
   localparam int CNT_W      = $clog2(DIVIDEND_W);
   localparam int MS_SCALE   = 1000;

   // Configuration port.
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_IDX_W-1:0] REG_WIDTH_SCALE  = 8'd0;
   localparam logic [CSR_IDX_W-1:0] REG_HEIGHT_SCALE = 8'd1;
   localparam logic [SCALE_W-1:0]   WIDTH_SCALE_RST  = 18'd69692;
   localparam logic [SCALE_W-1:0]   HEIGHT_SCALE_RST = 18'd50313;

   // Axis codes.
   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic scale;
      logic pos;
      logic check;
      logic mul;
      logic div_step;
      logic sat;
      logic out_load;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic upd;
      logic div_last;
      logic axis_last;
   } status_type;

endpackage

// ===== src/lvae_ifs.sv =====
// ----------------------------------------------------------------------------
// lvae interfaces: request, response and register write channels
// Each channel carries valid, ready and its payload word.
// ----------------------------------------------------------------------------
interface lvae_req_if;
   logic               valid;
   logic               ready;
   logic signed [17:0] x_fraction;
   logic signed [17:0] y_fraction;
   logic signed [15:0] depth_cm;
   logic [31:0]        timestamp_us;
   modport source (output valid, x_fraction, y_fraction, depth_cm, timestamp_us,
                   input ready);
   modport sink   (input valid, x_fraction, y_fraction, depth_cm, timestamp_us,
                   output ready);
endinterface

interface lvae_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] x_velocity;
   logic signed [31:0] y_velocity;
   logic signed [31:0] z_velocity;
   logic [32:0]        activity;
   logic               updated;
   modport source (output valid, x_velocity, y_velocity, z_velocity, activity, updated,
                   input ready);
   modport sink   (input valid, x_velocity, y_velocity, z_velocity, activity, updated,
                   output ready);
endinterface

interface lvae_csr_if;
   logic        valid;
   logic        ready;
   logic [7:0]  index;
   logic [31:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/lvae_ctrl.sv =====
// ----------------------------------------------------------------------------
// lvae_ctrl: sequencing controller
// Steps one word through scaling, ring update and, when it updates, three serial divisions.
// ----------------------------------------------------------------------------
module lvae_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output lvae_pkg::cmd_type    cmd,
   input  lvae_pkg::status_type status
);
   import lvae_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SCALE = 3'd1;
   localparam logic [2:0] ST_POS   = 3'd2;
   localparam logic [2:0] ST_CHECK = 3'd3;
   localparam logic [2:0] ST_MUL   = 3'd4;
   localparam logic [2:0] ST_DIV   = 3'd5;
   localparam logic [2:0] ST_SAT   = 3'd6;
   localparam logic [2:0] ST_OUT   = 3'd7;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   // Next state and commands.
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = ST_POS;
         end
         ST_POS: begin
            cmd.pos  = 1'b1;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            cmd.check = 1'b1;
            state_in  = status.upd ? ST_MUL : ST_OUT;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_SAT;
            end
         end
         ST_SAT: begin
            cmd.sat  = 1'b1;
            state_in = status.axis_last ? ST_OUT : ST_MUL;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Response valid flag; the result register waits here until taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== src/lvae_datapath.sv =====
// ----------------------------------------------------------------------------
// lvae_datapath: arithmetic, sample ring and result register
// Scales positions, keeps the ring, divides bit-serially and saturates.
// ----------------------------------------------------------------------------
module lvae_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  lvae_pkg::cmd_type             cmd,
   output lvae_pkg::status_type          status,
   input  logic                          csr_we,
   input  logic [lvae_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [lvae_pkg::CSR_DATA_W-1:0] csr_data,
   input  logic signed [lvae_pkg::FRAC_W-1:0]  in_x_fraction,
   input  logic signed [lvae_pkg::FRAC_W-1:0]  in_y_fraction,
   input  logic signed [lvae_pkg::DEPTH_W-1:0] in_depth_cm,
   input  logic [lvae_pkg::TIME_W-1:0]         in_timestamp_us,
   output logic signed [lvae_pkg::VEL_W-1:0]   out_x_velocity,
   output logic signed [lvae_pkg::VEL_W-1:0]   out_y_velocity,
   output logic signed [lvae_pkg::VEL_W-1:0]   out_z_velocity,
   output logic [lvae_pkg::ACT_W-1:0]          out_activity,
   output logic                                out_updated
);
   import lvae_pkg::*;

   localparam int WORD_W = 2 * POS_W + DEPTH_W + TIME_W;

   // Configuration registers.
   logic [SCALE_W-1:0] width_scale_ff, height_scale_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_scale_ff  <= WIDTH_SCALE_RST;
         height_scale_ff <= HEIGHT_SCALE_RST;
      end else if (csr_we) begin
         if (csr_index == REG_WIDTH_SCALE) begin
            width_scale_ff <= csr_data[SCALE_W-1:0];
         end else if (csr_index == REG_HEIGHT_SCALE) begin
            height_scale_ff <= csr_data[SCALE_W-1:0];
         end
      end
   end

   // Captured input word.
   logic signed [FRAC_W-1:0]  xf_ff, yf_ff;
   logic signed [DEPTH_W-1:0] z_ff;
   logic [TIME_W-1:0]         t_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         xf_ff <= in_x_fraction;
         yf_ff <= in_y_fraction;
         z_ff  <= in_depth_cm;
         t_ff  <= in_timestamp_us;
      end
   end

   // Ring slots.
   logic [SLOT_W-1:0] slot_ff, slot_in, old_slot;

   always_comb begin
      if (slot_ff >= SLOT_W'(LAG_MOD)) begin
         old_slot = slot_ff - SLOT_W'(LAG_MOD);
      end else begin
         old_slot = SLOT_W'(int'(slot_ff) + RING_DEPTH - LAG_MOD);
      end
      if (slot_ff == SLOT_W'(RING_DEPTH - 1)) begin
         slot_in = '0;
      end else begin
         slot_in = slot_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= '0;
      end else if (cmd.check) begin
         slot_ff <= slot_in;
      end
   end

   // Sample ring; an entry not yet written reads as zero.
   logic [WORD_W-1:0]     ring_mem [RING_DEPTH];
   logic [RING_DEPTH-1:0] ring_valid_ff;
   logic [WORD_W-1:0]     old_word_ff;
   logic                  old_valid_ff;
   logic signed [POS_W-1:0] xcm_ff, ycm_ff;

   always_ff @(posedge clock) begin
      if (cmd.check) begin
         ring_mem[slot_ff] <= {xcm_ff, ycm_ff, z_ff, t_ff};
      end
      if (cmd.load) begin
         old_word_ff <= ring_mem[old_slot];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ring_valid_ff <= '0;
         old_valid_ff  <= 1'b0;
      end else begin
         if (cmd.check) begin
            ring_valid_ff[slot_ff] <= 1'b1;
         end
         if (cmd.load) begin
            old_valid_ff <= ring_valid_ff[old_slot];
         end
      end
   end

   logic [WORD_W-1:0]         old_word;
   logic signed [POS_W-1:0]   old_x, old_y;
   logic signed [DEPTH_W-1:0] old_z;
   logic [TIME_W-1:0]         old_t;

   assign old_word = old_valid_ff ? old_word_ff : '0;
   assign {old_x, old_y, old_z, old_t} = old_word;

   // Picture sizes from depth.
   logic signed [DEPTH_W+SCALE_W:0] pw_prod, ph_prod, pw_mag, ph_mag;
   logic signed [PIC_W-1:0]         pw_ff, ph_ff;
   logic [DEPTH_W+SCALE_W-16:0]     pw_sh, ph_sh;

   always_comb begin
      pw_prod = z_ff * $signed({1'b0, width_scale_ff});
      ph_prod = z_ff * $signed({1'b0, height_scale_ff});
      pw_mag  = pw_prod[DEPTH_W+SCALE_W] ? -pw_prod : pw_prod;
      ph_mag  = ph_prod[DEPTH_W+SCALE_W] ? -ph_prod : ph_prod;
      pw_sh   = pw_mag[DEPTH_W+SCALE_W:16];
      ph_sh   = ph_mag[DEPTH_W+SCALE_W:16];
   end

   always_ff @(posedge clock) begin
      if (cmd.scale) begin
         pw_ff <= pw_prod[DEPTH_W+SCALE_W] ? -PIC_W'(pw_sh) : PIC_W'(pw_sh);
         ph_ff <= ph_prod[DEPTH_W+SCALE_W] ? -PIC_W'(ph_sh) : PIC_W'(ph_sh);
      end
   end

   // Positions in centimetres.
   logic signed [FRAC_W+PIC_W-1:0] xc_prod, yc_prod, xc_mag, yc_mag;

   always_comb begin
      xc_prod = xf_ff * pw_ff;
      yc_prod = yf_ff * ph_ff;
      xc_mag  = xc_prod[FRAC_W+PIC_W-1] ? -xc_prod : xc_prod;
      yc_mag  = yc_prod[FRAC_W+PIC_W-1] ? -yc_prod : yc_prod;
   end

   always_ff @(posedge clock) begin
      if (cmd.pos) begin
         xcm_ff <= xc_prod[FRAC_W+PIC_W-1] ? -POS_W'(xc_mag[FRAC_W+PIC_W-1:16])
                                          : POS_W'(xc_mag[FRAC_W+PIC_W-1:16]);
         ycm_ff <= yc_prod[FRAC_W+PIC_W-1] ? -POS_W'(yc_mag[FRAC_W+PIC_W-1:16])
                                          : POS_W'(yc_mag[FRAC_W+PIC_W-1:16]);
      end
   end

   // Time gap and update decision.
   logic [TIME_W-1:0] gap_ff, gap;
   logic              upd_now, upd_ff;

   assign gap     = t_ff - old_t;
   assign upd_now = !LAG_ALIAS && (old_t != '0) && (gap != '0);

   always_ff @(posedge clock) begin
      if (cmd.check) begin
         gap_ff <= gap;
         upd_ff <= upd_now;
      end
   end

   // Axis selection and magnitude of the difference.
   logic [1:0]              axis_ff;
   logic signed [MAG_W-1:0] delta;
   logic [MAG_W-1:0]        delta_mag;
   logic                    neg_ff;

   always_comb begin
      case (axis_ff)
         AXIS_X:  delta = MAG_W'(xcm_ff) - MAG_W'(old_x);
         AXIS_Y:  delta = MAG_W'(ycm_ff) - MAG_W'(old_y);
         default: delta = MAG_W'(z_ff) - MAG_W'(old_z);
      endcase
      delta_mag = delta[MAG_W-1] ? MAG_W'(-delta) : MAG_W'(delta);
   end

   // Restoring divider, one quotient bit a cycle.
   logic [DIVIDEND_W-1:0] quot_ff;
   logic [TIME_W-1:0]     rem_ff, rem_diff;
   logic [TIME_W:0]       rem_shift;
   logic [CNT_W-1:0]      cnt_ff;
   logic                  q_bit;

   always_comb begin
      rem_shift = {rem_ff, quot_ff[DIVIDEND_W-1]};
      q_bit     = rem_shift >= {1'b0, gap_ff};
      rem_diff  = TIME_W'(rem_shift - {1'b0, gap_ff});
   end

   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         quot_ff <= {MUL_W'(MUL_W'(delta_mag) * MUL_W'(MS_SCALE)), 16'd0};
         rem_ff  <= '0;
         cnt_ff  <= CNT_W'(DIVIDEND_W - 1);
         neg_ff  <= delta[MAG_W-1];
      end else if (cmd.div_step) begin
         quot_ff <= {quot_ff[DIVIDEND_W-2:0], q_bit};
         rem_ff  <= q_bit ? rem_diff : rem_shift[TIME_W-1:0];
         cnt_ff  <= cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         axis_ff <= AXIS_X;
      end else if (cmd.check) begin
         axis_ff <= AXIS_X;
      end else if (cmd.sat) begin
         axis_ff <= axis_ff + 1'b1;
      end
   end

   // Saturation into the held velocities.
   logic signed [VEL_W-1:0] held_ff [3];
   logic signed [VEL_W-1:0] sat_val;
   logic                    q_big;

   always_comb begin
      q_big = quot_ff[DIVIDEND_W-1:VEL_W-1] != '0;
      if (neg_ff) begin
         sat_val = q_big ? {1'b1, {(VEL_W-1){1'b0}}} : -VEL_W'(quot_ff[VEL_W-1:0]);
      end else begin
         sat_val = q_big ? {1'b0, {(VEL_W-1){1'b1}}} : VEL_W'(quot_ff[VEL_W-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff[0] <= '0;
         held_ff[1] <= '0;
         held_ff[2] <= '0;
      end else if (cmd.sat) begin
         held_ff[axis_ff] <= sat_val;
      end
   end

   // Activity and result register.
   logic [ACT_W-1:0] abs_x, abs_y, abs_z;

   always_comb begin
      abs_x = ACT_W'(held_ff[0][VEL_W-1] ? -{1'b1, held_ff[0]} : {1'b0, held_ff[0]});
      abs_y = ACT_W'(held_ff[1][VEL_W-1] ? -{1'b1, held_ff[1]} : {1'b0, held_ff[1]});
      abs_z = ACT_W'(held_ff[2][VEL_W-1] ? -{1'b1, held_ff[2]} : {1'b0, held_ff[2]});
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_x_velocity <= held_ff[0];
         out_y_velocity <= held_ff[1];
         out_z_velocity <= held_ff[2];
         out_activity   <= abs_x + abs_y + abs_z;
         out_updated    <= upd_ff;
      end
   end

   assign status.upd       = upd_now;
   assign status.div_last  = cnt_ff == '0;
   assign status.axis_last = axis_ff == AXIS_Z;

endmodule

// ===== src/lagged_velocity_activity_estimator_core.sv =====
// ----------------------------------------------------------------------------
// lagged_velocity_activity_estimator_core: lagged velocity and activity
// Turns sightings into cm, keeps a ring of samples and differences over a lag.
// ----------------------------------------------------------------------------
//  channel  | direction | word
//  req_bus  | in        | x_fraction, y_fraction, depth_cm, timestamp_us
//  rsp_bus  | out       | x/y/z_velocity, activity, updated
//  csr_bus  | in        | index, data (always ready)
//
// Velocities are held or recomputed per word; three restoring divisions of a
// 47-bit dividend dominate a recompute. Reset clears the ring valid bits, slot
// and held velocities and sets the scale registers to defaults. A result waits
// in its register while the next word is accepted and processed.
// ----------------------------------------------------------------------------
module lagged_velocity_activity_estimator_core (
   input logic       clock,
   input logic       reset,
   lvae_req_if.sink  req_bus,
   lvae_rsp_if.source rsp_bus,
   lvae_csr_if.sink  csr_bus
);
   import lvae_pkg::*;

   cmd_type    cmd;
   status_type status;

   assign csr_bus.ready = 1'b1;

   lvae_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .cmd       (cmd),
      .status    (status)
   );

   lvae_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .csr_we          (csr_bus.valid),
      .csr_index       (csr_bus.index),
      .csr_data        (csr_bus.data),
      .in_x_fraction   (req_bus.x_fraction),
      .in_y_fraction   (req_bus.y_fraction),
      .in_depth_cm     (req_bus.depth_cm),
      .in_timestamp_us (req_bus.timestamp_us),
      .out_x_velocity  (rsp_bus.x_velocity),
      .out_y_velocity  (rsp_bus.y_velocity),
      .out_z_velocity  (rsp_bus.z_velocity),
      .out_activity    (rsp_bus.activity),
      .out_updated     (rsp_bus.updated)
   );

endmodule
